// ----- rtl/pmfd_pkg.sv -----
// shared types, constants and the crc byte function of the power monitor frame decoder
`timescale 1ns / 1ps
`default_nettype none

package pmfd_pkg;

    localparam int HIT_COUNTER_BITS_DEF = 16;
    localparam int STORE_DEPTH          = 16384;
    localparam int STORE_AW             = $clog2(STORE_DEPTH);

    localparam logic [9:0] ROW_BITS   = 10'd32;
    localparam logic [7:0] HDR_BYTE   = 8'hFE;
    localparam logic [7:0] CRC_POLY   = 8'h07;
    localparam logic [7:0] CRC_RPOLY  = 8'h83;
    localparam logic [7:0] TRIAL_LAST = 8'd255;

    localparam logic [17:0] TEMP_SCALE  = 18'd436;
    localparam logic [17:0] TEMP_OFFSET = 18'd30360;

    localparam logic [15:0] THRESH_RESET = 16'd4;

    localparam logic [1:0] CFG_SENSOR_ID  = 2'd0;
    localparam logic [1:0] CFG_AUTO_LEARN = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd2;

    localparam logic [1:0] MSG_ID     = 2'd0;
    localparam logic [1:0] MSG_GAP    = 2'd1;
    localparam logic [1:0] MSG_TEMP   = 2'd2;
    localparam logic [1:0] MSG_ENERGY = 2'd3;

    typedef enum logic [1:0] {
        STATUS_BAD = 2'd0,
        STATUS_CRC = 2'd1,
        STATUS_OK  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_CRC_LO,
        ST_CRC_HI,
        ST_CHECK,
        ST_REV,
        ST_G_READ,
        ST_G_WRITE,
        ST_FINISH
    } t_state;

    // eight msb-first crc-8 shift steps (forward) or the eight inverse steps that undo them (reverse)
    function automatic logic [7:0] crc8_byte(input logic [7:0] x, input logic rev);
        logic [7:0] r;
        r = x;
        for (int b = 0; b < 8; b++) begin
            if (rev) begin
                r = r[0] ? ((r >> 1) ^ CRC_RPOLY) : (r >> 1);
            end else begin
                r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/pmfd_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module pmfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/power_monitor_frame_decoder.sv -----
// top level of the power monitor frame decoder
// Usage:
// - input channel (i_in_valid / o_in_stall) takes one received row: its bit
//   length and four raw bytes; a word is taken when valid is high and stall low
// - output channel (o_out_valid / i_out_stall) gives exactly one result word
//   per row; the result register holds while the receiver stalls, and the
//   block takes the next row meanwhile but does not finish it until the
//   result register is free
// - config port (i_cfg_valid / o_cfg_ready) writes sensor id, auto learn
//   and guess threshold; ready is high only while the block is idle
// - one row at a time: a good frame, or a crc error with no id guess, passes
//   through PREP, CRC_LO, CRC_HI, CHECK and FINISH; a bad length or header
//   goes from PREP to FINISH; the next row is taken at the earliest in the
//   cycle after the result loads
// - an id guess walks 256 trials, each a read (G_READ) then, for a trial whose
//   type matches, a write (G_WRITE) of the hit counter memory through its
//   single port pair, before FINISH
// - after reset all 16384 entries of the hit counter memory are zeroed one
//   entry a cycle, during which stall stays high
`timescale 1ns / 1ps
`default_nettype none

module power_monitor_frame_decoder #(
    parameter int HIT_COUNTER_BITS = pmfd_pkg::HIT_COUNTER_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [9:0]  i_row_length,
    input  wire logic [7:0]  i_raw_byte0,
    input  wire logic [7:0]  i_raw_byte1,
    input  wire logic [7:0]  i_raw_byte2,
    input  wire logic [7:0]  i_raw_byte3,

    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [1:0]       o_msg_type,
    output logic [15:0]      o_report_id,
    output logic [15:0]      o_value,
    output logic [5:0]       o_flags,
    output logic             o_batt_good,
    output logic signed [17:0] o_temp_milli_c,
    output logic             o_id_changed,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int AW    = pmfd_pkg::STORE_AW;
    localparam int CW    = HIT_COUNTER_BITS;
    localparam int CMP_W = (CW > 16) ? CW : 16;

    pmfd_pkg::t_state r_state, n_state;

    logic            r_current_id_we;
    logic [15:0]     r_current_id;
    logic            r_searching;
    logic [15:0]     r_thresh;

    logic            r_frame_ok;
    logic [7:0]      r_b1, r_b2, r_b3;
    logic [15:0]     r_off;
    logic [7:0]      r_crc;
    logic            r_crc_ok;
    logic            r_guessed;
    logic [7:0]      r_k;
    logic            r_match;
    logic [15:0]     r_id;
    logic [CW-1:0]   r_top_count;
    logic [15:0]     r_best_id;
    logic            r_best_unique;
    logic [AW-1:0]   r_clr_addr;

    // shared crc byte unit
    logic [7:0]      w_unit_in;
    logic            w_unit_rev;
    logic [7:0]      w_unit_out;

    logic            w_ram_we;
    logic [AW-1:0]   w_ram_waddr;
    logic [CW-1:0]   w_ram_wdata;
    logic [AW-1:0]   w_ram_raddr;
    logic [CW-1:0]   w_ram_rdata;

    logic            w_in_take;
    logic            w_cfg_take;
    logic            w_out_free;
    logic            w_finish;
    logic [1:0]      w_type;
    logic [15:0]     w_payload;
    logic [7:0]      w_trial_hi;
    logic [15:0]     w_trial_id;
    logic [CW-1:0]   w_cnt_inc;
    logic            w_guess_ok;

    logic [1:0]      w_res_status;
    logic [15:0]     w_res_report_id;
    logic [15:0]     w_res_value;
    logic [5:0]      w_res_flags;
    logic            w_res_batt_good;
    logic [17:0]     w_res_temp;
    logic            w_res_id_changed;

    assign w_in_take  = i_in_valid && !o_in_stall;
    assign w_cfg_take = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_finish   = (r_state == pmfd_pkg::ST_FINISH) && w_out_free;
    assign w_type     = r_b1[1:0];
    assign w_payload  = {r_b2, r_b1};
    assign w_trial_hi = r_b2 + r_k;
    assign w_trial_id = w_payload - {w_trial_hi, w_unit_out};
    assign w_cnt_inc  = (&w_ram_rdata) ? w_ram_rdata : w_ram_rdata + CW'(1);
    assign w_unit_out = pmfd_pkg::crc8_byte(w_unit_in, w_unit_rev);
    assign w_guess_ok = r_guessed && r_best_unique && (r_best_id != 16'd0)
                        && (CMP_W'(r_top_count) >= CMP_W'(r_thresh));

    pmfd_ram #(
        .WIDTH (CW),
        .DEPTH (pmfd_pkg::STORE_DEPTH)
    ) u_hits (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pmfd_pkg::ST_CLEAR: begin
                if (&r_clr_addr) n_state = pmfd_pkg::ST_IDLE;
            end
            pmfd_pkg::ST_IDLE: begin
                if (w_in_take) n_state = pmfd_pkg::ST_PREP;
            end
            pmfd_pkg::ST_PREP: begin
                n_state = r_frame_ok ? pmfd_pkg::ST_CRC_LO : pmfd_pkg::ST_FINISH;
            end
            pmfd_pkg::ST_CRC_LO: n_state = pmfd_pkg::ST_CRC_HI;
            pmfd_pkg::ST_CRC_HI: n_state = pmfd_pkg::ST_CHECK;
            pmfd_pkg::ST_CHECK: begin
                if (r_crc != r_b3 && r_searching && w_type != pmfd_pkg::MSG_ID) begin
                    n_state = pmfd_pkg::ST_REV;
                end else begin
                    n_state = pmfd_pkg::ST_FINISH;
                end
            end
            pmfd_pkg::ST_REV:    n_state = pmfd_pkg::ST_G_READ;
            pmfd_pkg::ST_G_READ: n_state = pmfd_pkg::ST_G_WRITE;
            pmfd_pkg::ST_G_WRITE: begin
                n_state = (r_k == pmfd_pkg::TRIAL_LAST) ? pmfd_pkg::ST_FINISH
                                                        : pmfd_pkg::ST_G_READ;
            end
            pmfd_pkg::ST_FINISH: begin
                if (w_out_free) n_state = pmfd_pkg::ST_IDLE;
            end
            default: n_state = pmfd_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        w_unit_in   = r_crc ^ w_trial_hi;
        w_unit_rev  = 1'b1;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_id[AW+1:2];
        w_ram_wdata = w_cnt_inc;
        w_ram_raddr = w_trial_id[AW+1:2];
        unique case (r_state)
            pmfd_pkg::ST_CLEAR: begin
                w_ram_we    = 1'b1;
                w_ram_waddr = r_clr_addr;
                w_ram_wdata = '0;
            end
            pmfd_pkg::ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cfg_ready = 1'b1;
            end
            pmfd_pkg::ST_CRC_LO: begin
                w_unit_in  = r_off[7:0];
                w_unit_rev = 1'b0;
            end
            pmfd_pkg::ST_CRC_HI: begin
                w_unit_in  = r_crc ^ r_off[15:8];
                w_unit_rev = 1'b0;
            end
            pmfd_pkg::ST_REV: w_unit_in = r_b3;
            pmfd_pkg::ST_G_WRITE: w_ram_we = r_match;
            default: begin
            end
        endcase
    end

    // result word
    always_comb begin
        w_res_status     = pmfd_pkg::STATUS_BAD;
        w_res_report_id  = '0;
        w_res_value      = '0;
        w_res_flags      = '0;
        w_res_batt_good  = 1'b0;
        w_res_temp       = '0;
        w_res_id_changed = 1'b0;
        if (r_frame_ok && !r_crc_ok) begin
            w_res_status     = pmfd_pkg::STATUS_CRC;
            w_res_report_id  = w_guess_ok ? r_best_id : r_current_id;
            w_res_id_changed = w_guess_ok;
        end else if (r_frame_ok) begin
            w_res_status    = pmfd_pkg::STATUS_OK;
            w_res_report_id = r_current_id;
            case (w_type)
                pmfd_pkg::MSG_ID: begin
                    w_res_report_id  = w_payload;
                    w_res_value      = w_payload;
                    w_res_id_changed = r_searching;
                end
                pmfd_pkg::MSG_TEMP: begin
                    w_res_flags     = r_off[7:2];
                    w_res_batt_good = !r_off[7];
                    w_res_temp      = pmfd_pkg::TEMP_SCALE * {10'd0, r_off[15:8]}
                                      - pmfd_pkg::TEMP_OFFSET;
                end
                default: w_res_value = r_off;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= pmfd_pkg::ST_CLEAR;
            r_clr_addr      <= '0;
            r_current_id    <= '0;
            r_searching     <= 1'b0;
            r_thresh        <= pmfd_pkg::THRESH_RESET;
            o_out_valid     <= 1'b0;
            r_current_id_we <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_current_id_we <= w_finish && w_res_id_changed;
            if (r_state == pmfd_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (w_finish) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            if (w_finish && w_res_id_changed) begin
                r_current_id <= w_res_report_id;
                r_searching  <= 1'b0;
            end
            if (w_cfg_take) begin
                unique case (i_cfg_index)
                    pmfd_pkg::CFG_SENSOR_ID:  r_current_id <= i_cfg_data;
                    pmfd_pkg::CFG_AUTO_LEARN: r_searching  <= i_cfg_data[0];
                    pmfd_pkg::CFG_THRESHOLD:  r_thresh     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state) inside
            pmfd_pkg::ST_IDLE: begin
                if (w_in_take) begin
                    r_frame_ok <= (i_row_length == pmfd_pkg::ROW_BITS)
                                  && (~i_raw_byte0 == pmfd_pkg::HDR_BYTE);
                    r_b1      <= ~i_raw_byte1;
                    r_b2      <= ~i_raw_byte2;
                    r_b3      <= ~i_raw_byte3;
                    r_crc_ok  <= 1'b0;
                    r_guessed <= 1'b0;
                end
            end
            pmfd_pkg::ST_PREP: begin
                r_off <= (w_type == pmfd_pkg::MSG_ID) ? w_payload : w_payload - r_current_id;
            end
            pmfd_pkg::ST_CRC_LO, pmfd_pkg::ST_CRC_HI: r_crc <= w_unit_out;
            pmfd_pkg::ST_CHECK: r_crc_ok <= (r_crc == r_b3);
            pmfd_pkg::ST_REV: begin
                r_crc         <= w_unit_out;
                r_k           <= '0;
                r_guessed     <= 1'b1;
                r_top_count   <= '0;
                r_best_id     <= '0;
                r_best_unique <= 1'b0;
            end
            pmfd_pkg::ST_G_READ: begin
                r_match <= (w_unit_out[1:0] == w_type);
                r_id    <= w_trial_id;
            end
            pmfd_pkg::ST_G_WRITE: begin
                r_k <= r_k + 8'd1;
                if (r_match) begin
                    if (w_cnt_inc > r_top_count) begin
                        r_top_count   <= w_cnt_inc;
                        r_best_id     <= r_id;
                        r_best_unique <= 1'b1;
                    end else if (w_cnt_inc == r_top_count) begin
                        r_best_unique <= 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        if (w_finish) begin
            o_status       <= w_res_status;
            o_msg_type     <= r_frame_ok ? w_type : pmfd_pkg::MSG_ID;
            o_report_id    <= w_res_report_id;
            o_value        <= w_res_value;
            o_flags        <= w_res_flags;
            o_batt_good    <= w_res_batt_good;
            o_temp_milli_c <= w_res_temp;
            o_id_changed   <= w_res_id_changed;
        end
    end

    a_bad_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == pmfd_pkg::STATUS_BAD |-> !o_id_changed)
        else $error("bad frame reported an id change");

    a_guess_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == pmfd_pkg::STATUS_CRC && o_id_changed
        |-> o_report_id != 16'd0)
        else $error("zero id adopted from guess");

    a_search_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $fell(r_searching)
        |-> $past(w_cfg_take) || $past(w_finish))
        else $error("searching cleared outside result or config write");

    a_id_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_current_id_we && !$past(w_cfg_take) |-> r_current_id == o_report_id)
        else $error("current id differs from reported new id");

endmodule

`default_nettype wire
